@@ src/fcpi_pkg.sv @@
package fcpi_pkg;

  localparam int MAX_POINTS = 6;
  localparam int NUM_POINTS = 6;
  localparam int PIDX_W     = $clog2(NUM_POINTS);

  localparam int TEMP_W  = 13;
  localparam int MAX_W   = 12;
  localparam int DUTY_W  = 8;
  localparam int DEG_W   = 8;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 3;

  localparam logic [DUTY_W-1:0] DEFAULT_DUTY = 8'd50;
  localparam logic [DUTY_W-1:0] DUTY_CEIL    = 8'd255;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [ADDR_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [ADDR_W-1:0] REG_POINT_COUNT = 3'd1;
  localparam logic [ADDR_W-1:0] REG_POINT_0     = 3'd2;

  typedef struct packed {
    logic [DEG_W-1:0]  temp;
    logic [DUTY_W-1:0] duty;
  } point_t;

  typedef struct packed {
    logic                        enable;
    logic [2:0]                  point_count;
    point_t [NUM_POINTS-1:0]     points;
  } cfg_t;

  typedef struct packed {
    logic             full;
    logic             valid;
    logic [MAX_W-1:0] data;
  } q_status_t;

endpackage

@@ src/fan_curve_pwm_interpolator_unit.sv @@
// Ordinary samples: one item per cycle while the queue is not full, no result.
// Last sample with enable set: its max goes to the queue; the back end settles the
// edge cases (empty curve, below first or past last point) in SCAN, clamps in CHK
// when the interpolation over- or underflows, and else runs its 8-step restoring divider.
// A 2-entry queue lets the front keep taking samples while the back divides.
// Synchronous active-high rst clears the config, back state, out_valid, running max and queue.
module fan_curve_pwm_interpolator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [fcpi_pkg::TEMP_W-1:0] temperature,
  input  logic                               last_sample,
  input  logic                               in_valid,
  output logic                               in_ready,
  output logic [fcpi_pkg::DUTY_W-1:0]        duty,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_write,
  input  logic [fcpi_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [fcpi_pkg::CFG_W-1:0]         cfg_data
);
  import fcpi_pkg::*;

  cfg_t             cfg;
  q_status_t        q_status;
  logic             push;
  logic [MAX_W-1:0] push_data;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_ENABLE:      cfg.enable      <= cfg_data[0];
        REG_POINT_COUNT: cfg.point_count <= cfg_data[2:0];
        default:         cfg.points[PIDX_W'(cfg_addr - REG_POINT_0)] <= cfg_data;
      endcase
    end
  end

  fcpi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .temperature (temperature),
    .last_sample (last_sample),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .enable      (cfg.enable),
    .q_full      (q_status.full),
    .push        (push),
    .push_data   (push_data)
  );

  fcpi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .status    (q_status)
  );

  fcpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .duty      (duty)
  );

endmodule

@@ src/fcpi_queue.sv @@
module fcpi_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [fcpi_pkg::MAX_W-1:0] push_data,
  input  logic                     pop,
  output fcpi_pkg::q_status_t      status
);
  import fcpi_pkg::*;

  logic [MAX_W-1:0]  mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.valid = (count != '0);
  assign status.data  = mem[rd_ptr];

endmodule

@@ src/fcpi_front.sv @@
module fcpi_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [fcpi_pkg::TEMP_W-1:0] temperature,
  input  logic                         last_sample,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         enable,
  input  logic                         q_full,
  output logic                         push,
  output logic [fcpi_pkg::MAX_W-1:0]   push_data
);
  import fcpi_pkg::*;

  logic [MAX_W-1:0] running_max;
  logic [MAX_W-1:0] max_next;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // negative samples never raise the max
  always_comb begin
    max_next = running_max;
    if (!temperature[TEMP_W-1] && (temperature[MAX_W-1:0] > running_max)) begin
      max_next = temperature[MAX_W-1:0];
    end
  end

  assign push      = accept && last_sample && enable;
  assign push_data = max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (accept) begin
      running_max <= last_sample ? '0 : max_next;
    end
  end

endmodule

@@ src/fcpi_back.sv @@
module fcpi_back (
  input  logic                        clk,
  input  logic                        rst,
  input  fcpi_pkg::cfg_t              cfg,
  input  fcpi_pkg::q_status_t         q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fcpi_pkg::DUTY_W-1:0] duty
);
  import fcpi_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SCAN, MUL1, MUL2, CHK, DIV, DONE
  } state_t;

  state_t               state;
  logic [MAX_W-1:0]     tmax;
  point_t               lo;
  point_t               hi;
  logic [15:0]          prod;
  logic signed [8:0]    dd;
  logic [MAX_W-1:0]     off;
  logic signed [21:0]   num;
  logic [MAX_W-1:0]     dvs;
  logic [20:0]          rem;
  logic [DUTY_W-1:0]    q;
  logic [2:0]           bit_idx;
  logic [DUTY_W-1:0]    res;

  logic [2:0]           n;
  logic [DEG_W-1:0]     whole;
  logic                 found;
  logic [PIDX_W-1:0]    idx;
  logic [DEG_W-1:0]     r;
  logic signed [21:0]   term_a;
  logic signed [21:0]   term_b;
  logic [20:0]          dvs_shift;
  logic                 out_free;

  always_comb begin
    n     = (cfg.point_count > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : cfg.point_count;
    whole = tmax[MAX_W-1:4];
    found = 1'b0;
    idx   = '0;
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      if ((3'(i) < n) && (cfg.points[i].temp >= whole)) begin
        found = 1'b1;
        idx   = PIDX_W'(i);
      end
    end
  end

  assign r         = hi.temp - lo.temp;
  assign term_a    = $signed({2'b00, prod, 4'b0000});
  assign term_b    = 22'(dd) * 22'($signed({1'b0, off}));
  assign dvs_shift = 21'({9'd0, dvs} << bit_idx);
  assign out_free  = !out_valid || out_ready;
  assign pop       = (state == IDLE) && q_status.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_status.valid) begin
            tmax  <= q_status.data;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (n == '0) begin
            res   <= DEFAULT_DUTY;
            state <= DONE;
          end else if (!found) begin
            res   <= cfg.points[PIDX_W'(n - 3'd1)].duty;
            state <= DONE;
          end else if (idx == '0) begin
            res   <= cfg.points[0].duty;
            state <= DONE;
          end else begin
            lo    <= cfg.points[idx - 1'b1];
            hi    <= cfg.points[idx];
            state <= MUL1;
          end
        end
        MUL1: begin
          prod  <= r * lo.duty;
          dd    <= $signed({1'b0, hi.duty}) - $signed({1'b0, lo.duty});
          off   <= tmax - {lo.temp, 4'b0000};
          dvs   <= {r, 4'b0000};
          state <= MUL2;
        end
        MUL2: begin
          num   <= term_a + term_b;
          state <= CHK;
        end
        CHK: begin
          if (num[21]) begin
            res   <= '0;
            state <= DONE;
          end else if (num[20:0] >= {1'b0, dvs, 8'd0}) begin
            res   <= DUTY_CEIL;
            state <= DONE;
          end else begin
            rem     <= num[20:0];
            q       <= '0;
            bit_idx <= 3'd7;
            state   <= DIV;
          end
        end
        DIV: begin
          if (rem >= dvs_shift) begin
            rem        <= rem - dvs_shift;
            q[bit_idx] <= 1'b1;
          end
          if (bit_idx == '0) begin
            res   <= q | ((rem >= dvs_shift) ? 8'd1 : 8'd0);
            state <= DONE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        DONE: begin
          if (out_free) begin
            duty  <= res;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ src/fcpi_checker.sv @@
module fcpi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               last_sample,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [fcpi_pkg::DUTY_W-1:0]        duty,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               cfg_write,
  input logic [fcpi_pkg::ADDR_W-1:0]        cfg_addr,
  input logic [fcpi_pkg::CFG_W-1:0]         cfg_data
);
  import fcpi_pkg::*;

  logic       en_mirror;
  logic [2:0] cnt_mirror;
  logic [2:0] pend;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready && last_sample && en_mirror;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_mirror  <= 1'b0;
      cnt_mirror <= '0;
      pend       <= '0;
    end else begin
      if (cfg_write && (cfg_addr == REG_ENABLE)) begin
        en_mirror <= cfg_data[0];
      end
      if (cfg_write && (cfg_addr == REG_POINT_COUNT)) begin
        cnt_mirror <= cfg_data[2:0];
      end
      if (in_take && !out_take) begin
        pend <= pend + 1'b1;
      end else if (out_take && !in_take) begin
        pend <= pend - 1'b1;
      end
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty))
    else $error("stalled result changed or dropped");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 3'd0)
    else $error("result without an enabled last sample");

  a_empty_curve: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cnt_mirror == 3'd0) |-> duty == DEFAULT_DUTY)
    else $error("empty curve must give default duty");

endmodule

bind fan_curve_pwm_interpolator_unit fcpi_checker u_fcpi_checker (.*);

@@ tb/tb_fan_curve_pwm_interpolator_unit.sv @@
module tb_fan_curve_pwm_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fcpi_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic                     last_sample = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [DUTY_W-1:0]        duty;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     cfg_write = 1'b0;
  logic [ADDR_W-1:0]        cfg_addr = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  fan_curve_pwm_interpolator_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .temperature (temperature),
    .last_sample (last_sample),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .duty        (duty),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg_write   (cfg_write),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the block's configuration and running maximum
  logic              curve_en = 1'b0;
  logic [2:0]        curve_count = '0;
  point_t            curve_pts [NUM_POINTS];
  logic [MAX_W-1:0]  peak_temp = '0;
  logic [DUTY_W-1:0] pending_duty [$];

  int         mismatches = 0;
  int         items_sent = 0;
  int         cycles = 0;
  int         src_gap_max = 0;
  int         src_burst = 0;
  sink_mode_e sink_mode = SINK_OPEN;
  logic [15:0] sink_shape = 16'hFFFF;
  logic [3:0]  sink_phase = '0;

  function automatic logic [DUTY_W-1:0] fan_duty_for(logic [MAX_W-1:0] peak);
    int unsigned n;
    int unsigned i;
    logic [DEG_W-1:0] whole;
    longint tl, tu, dl, du, off, span, num, q;
    n = (curve_count > MAX_POINTS) ? MAX_POINTS : curve_count;
    if (n == 0) return DEFAULT_DUTY;
    whole = peak[MAX_W-1:4];
    i = 0;
    while (i < n && curve_pts[i].temp < whole) i++;
    if (i == 0) return curve_pts[0].duty;
    if (i == n) return curve_pts[n-1].duty;
    tl = longint'(curve_pts[i-1].temp);
    dl = longint'(curve_pts[i-1].duty);
    tu = longint'(curve_pts[i].temp);
    du = longint'(curve_pts[i].duty);
    span = tu - tl;
    off = longint'(peak) - 16 * tl;
    num = 16 * span * dl + (du - dl) * off;
    if (num < 0) return '0;
    q = num / (16 * span);
    if (q > 255) return DUTY_CEIL;
    return q[DUTY_W-1:0];
  endfunction

  // Whole degree near the curve points so rounds hit every branch
  function automatic logic [DEG_W-1:0] pick_whole();
    int n, j, a, b, w;
    n = (curve_count > MAX_POINTS) ? MAX_POINTS : curve_count;
    if (n == 0 || $urandom_range(0, 7) == 0) return DEG_W'($urandom_range(0, 255));
    j = $urandom_range(0, n - 1);
    a = curve_pts[j].temp;
    if (j + 1 < n && $urandom_range(0, 2) == 0) begin
      b = curve_pts[j+1].temp;
      return DEG_W'($urandom_range(a, b));
    end
    w = a + int'($urandom_range(0, 6)) - 3;
    if (w < 0) w = 0;
    if (w > 255) w = 255;
    return DEG_W'(w);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    sink_phase <= sink_phase + 4'd1;
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      default:     out_ready <= sink_shape[sink_phase];
    endcase
  end

  always @(posedge clk) begin
    logic [DUTY_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_duty.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected duty item: got %0d", duty);
      end else begin
        want = pending_duty.pop_front();
        if (duty !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("duty mismatch: want %0d got %0d", want, duty);
        end
      end
    end
  end

  task automatic set_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:      curve_en = val[0];
      REG_POINT_COUNT: curve_count = val[2:0];
      default:         curve_pts[idx - REG_POINT_0] = val;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_point(int k, logic [DEG_W-1:0] deg, logic [DUTY_W-1:0] d);
    set_reg(ADDR_W'(REG_POINT_0 + k), {deg, d});
  endtask

  task automatic send_item(logic signed [TEMP_W-1:0] t, logic last);
    int gap;
    gap = 0;
    if (src_gap_max > 0) begin
      if (src_burst == 0) begin
        gap = $urandom_range(1, src_gap_max);
        src_burst = $urandom_range(1, 16);
      end else begin
        src_burst--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    temperature <= t;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    if (!t[TEMP_W-1] && t[MAX_W-1:0] > peak_temp) peak_temp = t[MAX_W-1:0];
    if (last) begin
      if (curve_en) pending_duty.push_back(fan_duty_for(peak_temp));
      peak_temp = '0;
    end
    items_sent++;
  endtask

  // A few samples, one carrying the peak, the rest not above it or negative
  task automatic send_round(int nsamp);
    logic [MAX_W-1:0] peak;
    logic [MAX_W-1:0] low;
    int pos;
    peak = {pick_whole(), 4'($urandom_range(0, 15))};
    pos = $urandom_range(0, nsamp - 1);
    for (int k = 0; k < nsamp; k++) begin
      if (k == pos) send_item({1'b0, peak}, k == nsamp - 1);
      else if ($urandom_range(0, 2) == 0) send_item({1'b1, 12'($urandom)}, k == nsamp - 1);
      else begin
        low = MAX_W'($urandom_range(0, peak));
        send_item({1'b0, low}, k == nsamp - 1);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_random_curve();
    int t, step_max;
    logic ordered;
    logic [DUTY_W-1:0] d;
    ordered = ($urandom_range(0, 7) != 0);
    t = $urandom_range(0, 40);
    for (int k = 0; k < NUM_POINTS; k++) begin
      if (!ordered) t = $urandom_range(0, 255);
      else if (k > 0) begin
        step_max = (255 - t) / (NUM_POINTS - k);
        if (step_max < 1) step_max = 1;
        t = t + $urandom_range(1, step_max);
      end
      case ($urandom_range(0, 5))
        0:       d = '0;
        1:       d = '1;
        default: d = DUTY_W'($urandom);
      endcase
      set_point(k, DEG_W'(t), d);
    end
    case ($urandom_range(0, 7))
      0:       set_reg(REG_POINT_COUNT, {13'($urandom), 3'd0});
      1:       set_reg(REG_POINT_COUNT, {13'($urandom), 3'd7});
      default: set_reg(REG_POINT_COUNT, {13'($urandom), 3'($urandom_range(1, 6))});
    endcase
    set_reg(REG_ENABLE, {15'($urandom), ($urandom_range(0, 7) != 0)});
  endtask

  task automatic test_disabled_at_reset();
    send_item(TEMP_W'(1600), 1'b0);
    send_item(TEMP_W'(100), 1'b1);
    wait_idle();
  endtask

  task automatic test_empty_curve();
    set_reg(REG_ENABLE, 16'h0001);
    send_item(TEMP_W'(4095), 1'b1);
    wait_idle();
  endtask

  task automatic test_curve_edges();
    set_point(0, 8'd20, 8'd30);
    set_point(1, 8'd40, 8'd200);
    set_point(2, 8'd60, 8'd100);
    set_point(3, 8'd255, 8'd255);
    set_reg(REG_POINT_COUNT, 16'd4);
    send_item(TEMP_W'(-4096), 1'b1);
    send_item(TEMP_W'(0), 1'b1);
    send_item(TEMP_W'(4095), 1'b1);
    send_item(TEMP_W'(30 * 16 + 8), 1'b0);
    send_item(TEMP_W'(-5), 1'b1);
    send_item(TEMP_W'(40 * 16), 1'b1);
    send_item(TEMP_W'(40 * 16 + 15), 1'b1);
    wait_idle();
    // disabled last sample still clears the maximum
    set_reg(REG_ENABLE, 16'h0000);
    send_item(TEMP_W'(4000), 1'b1);
    wait_idle();
    set_reg(REG_ENABLE, 16'h0001);
    send_item(TEMP_W'(16), 1'b1);
    wait_idle();
  endtask

  task automatic test_clamping();
    set_point(0, 8'd10, 8'd0);
    set_point(1, 8'd11, 8'd255);
    set_reg(REG_POINT_COUNT, 16'd2);
    send_item(TEMP_W'(11 * 16 + 15), 1'b1);
    send_item(TEMP_W'(12 * 16), 1'b1);
    wait_idle();
    set_point(0, 8'd10, 8'd255);
    set_point(1, 8'd11, 8'd0);
    send_item(TEMP_W'(11 * 16 + 15), 1'b1);
    wait_idle();
  endtask

  task automatic test_count_overflow();
    for (int k = 0; k < NUM_POINTS; k++) set_point(k, DEG_W'(10 + 30 * k), DUTY_W'(40 * k + 7));
    set_reg(REG_POINT_COUNT, 16'hFFFF);
    send_item(TEMP_W'(4095), 1'b1);
    send_item(TEMP_W'(95 * 16 + 3), 1'b1);
    wait_idle();
  endtask

  task automatic test_unordered_points();
    set_point(0, 8'd50, 8'd10);
    set_point(1, 8'd20, 8'd90);
    set_point(2, 8'd80, 8'd250);
    set_reg(REG_POINT_COUNT, 16'd3);
    send_item(TEMP_W'(30 * 16), 1'b1);
    send_item(TEMP_W'(60 * 16 + 9), 1'b1);
    wait_idle();
  endtask

  task automatic test_random_rounds();
    int start, phase_end;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      load_random_curve();
      case ($urandom_range(0, 3))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = 12;
      endcase
      src_burst = 0;
      case ($urandom_range(0, 3))
        0: sink_mode = SINK_OPEN;
        1: sink_mode = SINK_RANDOM;
        default: begin
          sink_mode = SINK_PATTERN;
          sink_shape = 16'($urandom) | 16'h0001;
        end
      endcase
      phase_end = items_sent + $urandom_range(80, 180);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) send_item(13'($urandom), $urandom_range(0, 4) == 0);
        else send_round($urandom_range(1, 6));
      end
      wait_idle();
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_POINTS; k++) curve_pts[k] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sink_mode = SINK_RANDOM;
    src_gap_max = 4;
    test_disabled_at_reset();
    test_empty_curve();
    test_curve_edges();
    test_clamping();
    test_count_overflow();
    test_unordered_points();
    test_random_rounds();
    wait_idle();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ fan_curve_pwm_interpolator_unit.f @@
src/fcpi_pkg.sv
src/fcpi_queue.sv
src/fcpi_front.sv
src/fcpi_back.sv
src/fan_curve_pwm_interpolator_unit.sv
src/fcpi_checker.sv
tb/tb_fan_curve_pwm_interpolator_unit.sv
